// ----- src/hfe_pkg.sv -----
// ----------------------------------------------------------------------------
// hfe_pkg
// Shared widths, limits and action codes for the byte symbol Huffman encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hfe_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_W       = 32;
   localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   localparam int ACTION_W     = 2;
   localparam int SYM_W        = 8;
   localparam int LEN_W        = 6;
   localparam int BYTE_W       = 8;
   localparam int PAD_W        = 3;
   localparam int PEND_W       = 7;
   localparam int CNT_W        = 3;
   localparam int ACC_W        = PEND_W + CODE_W;
   localparam int TOT_W        = 6;

   localparam int TABLE_DEPTH  = 256;
   localparam int ADDR_W       = 8;
   localparam int ENTRY_W      = CODE_W + LEN_W;

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

endpackage

`default_nettype wire

// ----- src/hfe_ram.sv -----
// ----------------------------------------------------------------------------
// hfe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/huffman_encoder_bit_packer_top.sv -----
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer_top
// Byte symbol Huffman encoder: code table in RAM, bit accumulator, byte packer.
// ----------------------------------------------------------------------------
// After reset the block clears its 256-entry code table, one entry a cycle, and
// takes no request until the clear is done. A load request writes one table
// entry. An encode request reads the table (registered RAM read data), appends
// the code to the pending bits and sends floor((p+L)/8) bytes, p pending bits
// plus L code bits, one byte per cycle on the result channel while rsp_ready
// is high. A flush sends exactly one result marked last. A request can be
// taken while the previous one's bytes still drain; the table read stage
// holds as a skid until the byte register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_encoder_bit_packer_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [hfe_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [hfe_pkg::SYM_W-1:0]     req_symbol,
   input  wire logic [hfe_pkg::CODE_W-1:0]    req_code_bits,
   input  wire logic [hfe_pkg::LEN_W-1:0]     req_code_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [hfe_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                               rsp_byte_valid,
   output logic      [hfe_pkg::PAD_W-1:0]     rsp_pad_bits,
   output logic                               rsp_last
);

   import hfe_pkg::*;

   logic                 clr_ff;
   logic                 clr_in;
   logic [ADDR_W-1:0]    clr_addr_ff;
   logic [ADDR_W-1:0]    clr_addr_in;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_flush_ff;
   logic                 s1_flush_in;

   logic [PEND_W-1:0]    pend_bits_ff;
   logic [PEND_W-1:0]    pend_bits_in;
   logic [CNT_W-1:0]     pend_cnt_ff;
   logic [CNT_W-1:0]     pend_cnt_in;

   logic [ACC_W-1:0]     em_acc_ff;
   logic [ACC_W-1:0]     em_acc_in;
   logic [TOT_W-1:0]     em_total_ff;
   logic [TOT_W-1:0]     em_total_in;
   logic                 em_bvalid_ff;
   logic                 em_bvalid_in;
   logic [PAD_W-1:0]     em_pad_ff;
   logic [PAD_W-1:0]     em_pad_in;
   logic                 em_last_ff;
   logic                 em_last_in;

   logic                 req_xfer;
   logic                 rsp_xfer;
   logic                 load_wr;
   logic [LEN_W-1:0]     load_len;
   logic [CODE_W-1:0]    load_code;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [ENTRY_W-1:0]   ram_rd_data;

   logic [CODE_W-1:0]    rd_code;
   logic [LEN_W-1:0]     rd_len;
   logic [TOT_W-1:0]     enc_total;
   logic [ACC_W-1:0]     enc_acc;
   logic [PEND_W-1:0]    enc_pend;
   logic [PAD_W-1:0]     fl_pad;
   logic [BYTE_W-1:0]    fl_byte;
   logic                 s1_emits;
   logic                 em_free;
   logic                 s1_advance;
   logic [TOT_W-1:0]     em_shift;

   // table
   hfe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_symbol),
      .rd_data (ram_rd_data)
   );

   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign load_wr   = req_xfer && (req_action == ACT_LOAD);
   assign ram_rd_en = req_xfer && (req_action == ACT_ENCODE);

   // saturate length, drop code bits above it
   always_comb begin
      if (req_code_length > LEN_W'(LEN_LIMIT)) begin
         load_len = LEN_W'(LEN_LIMIT);
      end else begin
         load_len = req_code_length;
      end
      load_code = req_code_bits & ~({CODE_W{1'b1}} << load_len);
   end

   assign ram_wr_en   = clr_ff || load_wr;
   assign ram_wr_addr = clr_ff ? clr_addr_ff : req_symbol;
   assign ram_wr_data = clr_ff ? '0 : {load_len, load_code};

   assign rd_code = ram_rd_data[CODE_W-1:0];
   assign rd_len  = ram_rd_data[ENTRY_W-1:CODE_W];

   always_comb begin
      enc_total = TOT_W'(pend_cnt_ff) + TOT_W'(rd_len);
      enc_acc   = (ACC_W'(pend_bits_ff) << rd_len) | ACC_W'(rd_code);
      enc_pend  = enc_acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << enc_total[CNT_W-1:0]);
      fl_pad    = PAD_W'(BYTE_W) - pend_cnt_ff;
      fl_byte   = BYTE_W'({1'b0, pend_bits_ff} << fl_pad);
   end

   assign rsp_valid  = (em_total_ff[TOT_W-1:3] != '0);
   assign em_free    = !rsp_valid || (rsp_ready && (em_total_ff[TOT_W-1:3] == 3'd1));
   assign s1_emits   = s1_flush_ff || (enc_total[TOT_W-1:3] != '0);
   assign s1_advance = s1_valid_ff && (!s1_emits || em_free);
   assign req_ready  = !clr_ff && (!s1_valid_ff || s1_advance);

   assign em_shift       = em_total_ff - TOT_W'(BYTE_W);
   assign rsp_out_byte   = BYTE_W'(em_acc_ff >> em_shift);
   assign rsp_byte_valid = em_bvalid_ff;
   assign rsp_pad_bits   = em_pad_ff;
   assign rsp_last       = em_last_ff;

   always_comb begin
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      s1_valid_in  = s1_valid_ff;
      s1_flush_in  = s1_flush_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      em_acc_in    = em_acc_ff;
      em_total_in  = em_total_ff;
      em_bvalid_in = em_bvalid_ff;
      em_pad_in    = em_pad_ff;
      em_last_in   = em_last_ff;

      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == {ADDR_W{1'b1}}) begin
            clr_in = 1'b0;
         end
      end

      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_xfer && (req_action == ACT_ENCODE || req_action == ACT_FLUSH)) begin
         s1_valid_in = 1'b1;
         s1_flush_in = (req_action == ACT_FLUSH);
      end

      // drain one byte per transfer
      if (rsp_xfer) begin
         em_total_in = em_shift;
      end

      if (s1_advance) begin
         if (s1_flush_ff) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
            em_acc_in    = ACC_W'(fl_byte);
            em_total_in  = TOT_W'(BYTE_W);
            em_bvalid_in = (pend_cnt_ff != '0);
            em_pad_in    = (pend_cnt_ff != '0) ? fl_pad : '0;
            em_last_in   = 1'b1;
         end else begin
            pend_bits_in = enc_pend;
            pend_cnt_in  = enc_total[CNT_W-1:0];
            if (s1_emits) begin
               em_acc_in    = enc_acc;
               em_total_in  = enc_total;
               em_bvalid_in = 1'b1;
               em_pad_in    = '0;
               em_last_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s1_flush_ff  <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         em_total_ff  <= '0;
         em_bvalid_ff <= 1'b0;
         em_pad_ff    <= '0;
         em_last_ff   <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s1_flush_ff  <= s1_flush_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         em_total_ff  <= em_total_in;
         em_bvalid_ff <= em_bvalid_in;
         em_pad_ff    <= em_pad_in;
         em_last_ff   <= em_last_in;
      end
   end

   always_ff @(posedge clock) begin
      em_acc_ff <= em_acc_in;
   end

   // no request while the table is being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_ready)
      else $error("request taken during table clear");

   // table read data holds while the lookup stage is stalled
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> $stable(ram_rd_data))
      else $error("table read data lost under stall");

   // a flush leaves nothing pending
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_flush_ff) |=> (pend_cnt_ff == '0))
      else $error("pending bits survive flush");

   // a last result is a single byte
   a_last_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (em_total_ff == TOT_W'(BYTE_W)))
      else $error("last result not a single byte");

endmodule

`default_nettype wire
